// ===== rtl/des_pkg.sv =====
// ----------------------------------------------------------------------------
// des_pkg
// DES constant tables, stage types and the permutation / round functions.
// ----------------------------------------------------------------------------
`default_nettype none

package des_pkg;

    localparam int NUM_ROUNDS = 16;

    typedef logic [47:0] des_subkey_t;

    // payload carried between round stages
    typedef struct packed {
        logic        func;
        logic [31:0] l;
        logic [31:0] r;
    } des_blk_t;

    localparam logic [6:0] IP_TBL [64] = '{
        7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
        7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
        7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
        7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
        7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
        7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
        7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
        7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7
    };

    localparam logic [6:0] FP_TBL [64] = '{
        7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
        7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
        7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
        7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
        7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
        7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
        7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
        7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25
    };

    localparam logic [5:0] E_TBL [48] = '{
        6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,
        6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
        6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13,
        6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
        6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21,
        6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
        6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29,
        6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
    };

    localparam logic [5:0] P_TBL [32] = '{
        6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
        6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
        6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
        6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
    };

    localparam logic [6:0] PC1_TBL [56] = '{
        7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
        7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
        7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
        7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
        7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
        7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
        7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
        7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
    };

    localparam logic [5:0] PC2_TBL [48] = '{
        6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,
        6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
        6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,
        6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
        6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55,
        6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
        6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53,
        6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
    };

    // cumulative left rotation of C and D for each round
    localparam logic [4:0] ROT_TBL [16] = '{
        5'd1,  5'd2,  5'd4,  5'd6,  5'd8,  5'd10, 5'd12, 5'd14,
        5'd15, 5'd17, 5'd19, 5'd21, 5'd23, 5'd25, 5'd27, 5'd28
    };

    localparam logic [3:0] SBOX_TBL [8][64] = '{
        '{4'd14, 4'd4,  4'd13, 4'd1,  4'd2,  4'd15, 4'd11, 4'd8,
          4'd3,  4'd10, 4'd6,  4'd12, 4'd5,  4'd9,  4'd0,  4'd7,
          4'd0,  4'd15, 4'd7,  4'd4,  4'd14, 4'd2,  4'd13, 4'd1,
          4'd10, 4'd6,  4'd12, 4'd11, 4'd9,  4'd5,  4'd3,  4'd8,
          4'd4,  4'd1,  4'd14, 4'd8,  4'd13, 4'd6,  4'd2,  4'd11,
          4'd15, 4'd12, 4'd9,  4'd7,  4'd3,  4'd10, 4'd5,  4'd0,
          4'd15, 4'd12, 4'd8,  4'd2,  4'd4,  4'd9,  4'd1,  4'd7,
          4'd5,  4'd11, 4'd3,  4'd14, 4'd10, 4'd0,  4'd6,  4'd13},
        '{4'd15, 4'd1,  4'd8,  4'd14, 4'd6,  4'd11, 4'd3,  4'd4,
          4'd9,  4'd7,  4'd2,  4'd13, 4'd12, 4'd0,  4'd5,  4'd10,
          4'd3,  4'd13, 4'd4,  4'd7,  4'd15, 4'd2,  4'd8,  4'd14,
          4'd12, 4'd0,  4'd1,  4'd10, 4'd6,  4'd9,  4'd11, 4'd5,
          4'd0,  4'd14, 4'd7,  4'd11, 4'd10, 4'd4,  4'd13, 4'd1,
          4'd5,  4'd8,  4'd12, 4'd6,  4'd9,  4'd3,  4'd2,  4'd15,
          4'd13, 4'd8,  4'd10, 4'd1,  4'd3,  4'd15, 4'd4,  4'd2,
          4'd11, 4'd6,  4'd7,  4'd12, 4'd0,  4'd5,  4'd14, 4'd9},
        '{4'd10, 4'd0,  4'd9,  4'd14, 4'd6,  4'd3,  4'd15, 4'd5,
          4'd1,  4'd13, 4'd12, 4'd7,  4'd11, 4'd4,  4'd2,  4'd8,
          4'd13, 4'd7,  4'd0,  4'd9,  4'd3,  4'd4,  4'd6,  4'd10,
          4'd2,  4'd8,  4'd5,  4'd14, 4'd12, 4'd11, 4'd15, 4'd1,
          4'd13, 4'd6,  4'd4,  4'd9,  4'd8,  4'd15, 4'd3,  4'd0,
          4'd11, 4'd1,  4'd2,  4'd12, 4'd5,  4'd10, 4'd14, 4'd7,
          4'd1,  4'd10, 4'd13, 4'd0,  4'd6,  4'd9,  4'd8,  4'd7,
          4'd4,  4'd15, 4'd14, 4'd3,  4'd11, 4'd5,  4'd2,  4'd12},
        '{4'd7,  4'd13, 4'd14, 4'd3,  4'd0,  4'd6,  4'd9,  4'd10,
          4'd1,  4'd2,  4'd8,  4'd5,  4'd11, 4'd12, 4'd4,  4'd15,
          4'd13, 4'd8,  4'd11, 4'd5,  4'd6,  4'd15, 4'd0,  4'd3,
          4'd4,  4'd7,  4'd2,  4'd12, 4'd1,  4'd10, 4'd14, 4'd9,
          4'd10, 4'd6,  4'd9,  4'd0,  4'd12, 4'd11, 4'd7,  4'd13,
          4'd15, 4'd1,  4'd3,  4'd14, 4'd5,  4'd2,  4'd8,  4'd4,
          4'd3,  4'd15, 4'd0,  4'd6,  4'd10, 4'd1,  4'd13, 4'd8,
          4'd9,  4'd4,  4'd5,  4'd11, 4'd12, 4'd7,  4'd2,  4'd14},
        '{4'd2,  4'd12, 4'd4,  4'd1,  4'd7,  4'd10, 4'd11, 4'd6,
          4'd8,  4'd5,  4'd3,  4'd15, 4'd13, 4'd0,  4'd14, 4'd9,
          4'd14, 4'd11, 4'd2,  4'd12, 4'd4,  4'd7,  4'd13, 4'd1,
          4'd5,  4'd0,  4'd15, 4'd10, 4'd3,  4'd9,  4'd8,  4'd6,
          4'd4,  4'd2,  4'd1,  4'd11, 4'd10, 4'd13, 4'd7,  4'd8,
          4'd15, 4'd9,  4'd12, 4'd5,  4'd6,  4'd3,  4'd0,  4'd14,
          4'd11, 4'd8,  4'd12, 4'd7,  4'd1,  4'd14, 4'd2,  4'd13,
          4'd6,  4'd15, 4'd0,  4'd9,  4'd10, 4'd4,  4'd5,  4'd3},
        '{4'd12, 4'd1,  4'd10, 4'd15, 4'd9,  4'd2,  4'd6,  4'd8,
          4'd0,  4'd13, 4'd3,  4'd4,  4'd14, 4'd7,  4'd5,  4'd11,
          4'd10, 4'd15, 4'd4,  4'd2,  4'd7,  4'd12, 4'd9,  4'd5,
          4'd6,  4'd1,  4'd13, 4'd14, 4'd0,  4'd11, 4'd3,  4'd8,
          4'd9,  4'd14, 4'd15, 4'd5,  4'd2,  4'd8,  4'd12, 4'd3,
          4'd7,  4'd0,  4'd4,  4'd10, 4'd1,  4'd13, 4'd11, 4'd6,
          4'd4,  4'd3,  4'd2,  4'd12, 4'd9,  4'd5,  4'd15, 4'd10,
          4'd11, 4'd14, 4'd1,  4'd7,  4'd6,  4'd0,  4'd8,  4'd13},
        '{4'd4,  4'd11, 4'd2,  4'd14, 4'd15, 4'd0,  4'd8,  4'd13,
          4'd3,  4'd12, 4'd9,  4'd7,  4'd5,  4'd10, 4'd6,  4'd1,
          4'd13, 4'd0,  4'd11, 4'd7,  4'd4,  4'd9,  4'd1,  4'd10,
          4'd14, 4'd3,  4'd5,  4'd12, 4'd2,  4'd15, 4'd8,  4'd6,
          4'd1,  4'd4,  4'd11, 4'd13, 4'd12, 4'd3,  4'd7,  4'd14,
          4'd10, 4'd15, 4'd6,  4'd8,  4'd0,  4'd5,  4'd9,  4'd2,
          4'd6,  4'd11, 4'd13, 4'd8,  4'd1,  4'd4,  4'd10, 4'd7,
          4'd9,  4'd5,  4'd0,  4'd15, 4'd14, 4'd2,  4'd3,  4'd12},
        '{4'd13, 4'd2,  4'd8,  4'd4,  4'd6,  4'd15, 4'd11, 4'd1,
          4'd10, 4'd9,  4'd3,  4'd14, 4'd5,  4'd0,  4'd12, 4'd7,
          4'd1,  4'd15, 4'd13, 4'd8,  4'd10, 4'd3,  4'd7,  4'd4,
          4'd12, 4'd5,  4'd6,  4'd11, 4'd0,  4'd14, 4'd9,  4'd2,
          4'd7,  4'd11, 4'd4,  4'd1,  4'd9,  4'd12, 4'd14, 4'd2,
          4'd0,  4'd6,  4'd10, 4'd13, 4'd15, 4'd3,  4'd5,  4'd8,
          4'd2,  4'd1,  4'd14, 4'd7,  4'd4,  4'd10, 4'd8,  4'd13,
          4'd15, 4'd12, 4'd9,  4'd0,  4'd3,  4'd5,  4'd6,  4'd11}
    };

    // Table positions are 1-based, counted from the MSB of the source word.
    function automatic logic [63:0] perm_ip(logic [63:0] v);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[63-i] = v[64-int'(IP_TBL[i])];
        return r;
    endfunction

    function automatic logic [63:0] perm_fp(logic [63:0] v);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[63-i] = v[64-int'(FP_TBL[i])];
        return r;
    endfunction

    function automatic logic [47:0] perm_e(logic [31:0] v);
        logic [47:0] r;
        for (int i = 0; i < 48; i++) r[47-i] = v[32-int'(E_TBL[i])];
        return r;
    endfunction

    function automatic logic [31:0] perm_p(logic [31:0] v);
        logic [31:0] r;
        for (int i = 0; i < 32; i++) r[31-i] = v[32-int'(P_TBL[i])];
        return r;
    endfunction

    function automatic logic [55:0] perm_pc1(logic [63:0] v);
        logic [55:0] r;
        for (int i = 0; i < 56; i++) r[55-i] = v[64-int'(PC1_TBL[i])];
        return r;
    endfunction

    function automatic logic [47:0] perm_pc2(logic [55:0] v);
        logic [47:0] r;
        for (int i = 0; i < 48; i++) r[47-i] = v[56-int'(PC2_TBL[i])];
        return r;
    endfunction

    // constant-amount rotate left of a 28-bit half, s in 1..28
    function automatic logic [27:0] rotl28(logic [27:0] x, int s);
        logic [55:0] dbl;
        dbl = {x, x} >> (28 - s);
        return dbl[27:0];
    endfunction

    function automatic logic [31:0] feistel(logic [31:0] r, des_subkey_t k);
        logic [47:0] x;
        logic [5:0]  b;
        logic [31:0] o;
        x = perm_e(r) ^ k;
        for (int s = 0; s < 8; s++) begin
            b = x[47-6*s -: 6];
            o[31-4*s -: 4] = SBOX_TBL[s][{b[5], b[0], b[4:1]}];
        end
        return perm_p(o);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/des_if.sv =====
// ----------------------------------------------------------------------------
// des_if
// Valid/ready channels: input blocks, result blocks and key writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface des_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [63:0] data_in;

    modport source (output valid, output func, output data_in, input ready);
    modport sink   (input valid, input func, input data_in, output ready);
endinterface

interface des_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_out;

    modport source (output valid, output data_out, input ready);
    modport sink   (input valid, input data_out, output ready);
endinterface

interface des_cfg_if;
    logic        valid;
    logic        ready;
    logic [63:0] key;

    modport source (output valid, output key, input ready);
    modport sink   (input valid, input key, output ready);
endinterface

`default_nettype wire

// ===== rtl/des_key_sched.sv =====
// ----------------------------------------------------------------------------
// des_key_sched
// Key register and the sixteen round subkeys (PC1, rotations, PC2).
// ----------------------------------------------------------------------------
`default_nettype none

module des_key_sched
    import des_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    des_cfg_if.sink     cfg,
    output des_subkey_t subkey [NUM_ROUNDS]
);

    logic [63:0] key_reg;
    logic [55:0] cd;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (cfg.valid)
        begin
            key_reg <= cfg.key;
        end
    end

    assign cd = perm_pc1(key_reg);

    // rotations are cumulative per round, so each subkey is pure wiring
    for (genvar i = 0; i < NUM_ROUNDS; i++)
    begin : g_sub
        assign subkey[i] = perm_pc2({rotl28(cd[55:28], int'(ROT_TBL[i])),
                                     rotl28(cd[27:0],  int'(ROT_TBL[i]))});
    end

endmodule

`default_nettype wire

// ===== rtl/des_round.sv =====
// ----------------------------------------------------------------------------
// des_round
// One Feistel round as a registered pipeline stage with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

module des_round
    import des_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        up_valid,
    output logic             up_ready,
    input  wire des_blk_t    up_blk,
    input  wire des_subkey_t enc_key,
    input  wire des_subkey_t dec_key,
    output logic             dn_valid,
    input  wire logic        dn_ready,
    output des_blk_t         dn_blk
);

    logic        valid_reg;
    des_blk_t    blk_reg;
    des_blk_t    blk_next;
    des_subkey_t rkey;

    assign up_ready = !valid_reg || dn_ready;
    assign rkey     = up_blk.func ? dec_key : enc_key;

    always_comb
    begin
        blk_next.func = up_blk.func;
        blk_next.l    = up_blk.r;
        blk_next.r    = up_blk.l ^ feistel(up_blk.r, rkey);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            blk_reg <= blk_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_blk   = blk_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !dn_ready |=> valid_reg && $stable(blk_reg))
        else $error("stalled stage lost or changed its beat");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg |-> up_ready)
        else $error("empty stage refused a beat");

    a_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        up_ready && !up_valid |=> !valid_reg)
        else $error("stage invented a beat");

endmodule

`default_nettype wire

// ===== rtl/des_block_cipher_unit.sv =====
// ----------------------------------------------------------------------------
// des_block_cipher_unit
// DES ECB engine: IP, sixteen pipelined Feistel rounds, FP.
// ----------------------------------------------------------------------------
//  channel  dir  payload                    beat when
//  req      in   func, data_in[63:0]        req.valid && req.ready
//  rsp      out  data_out[63:0]             rsp.valid && rsp.ready
//  cfg      in   key[63:0]                  cfg.valid && cfg.ready (always ready)
//
//  One block per cycle sustained while rsp is ready; one register per round.
//  IP and FP are wiring at the entry and exit; the last round's register is
//  the output register.
//  A stall at rsp holds full stages with a full successor; empty stages still
//  fill (bubbles collapse). Reset clears the stage valids and sets the key to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module des_block_cipher_unit
    import des_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    des_in_if.sink    req,
    des_out_if.source rsp,
    des_cfg_if.sink   cfg
);

    des_subkey_t subkey [NUM_ROUNDS];
    logic        stg_valid [NUM_ROUNDS+1];
    logic        stg_ready [NUM_ROUNDS+1];
    des_blk_t    stg_blk   [NUM_ROUNDS+1];
    logic [63:0] ip_out;

    des_key_sched u_key (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .subkey (subkey)
    );

    assign ip_out         = perm_ip(req.data_in);
    assign stg_valid[0]   = req.valid;
    assign stg_blk[0].func = req.func;
    assign stg_blk[0].l   = ip_out[63:32];
    assign stg_blk[0].r   = ip_out[31:0];
    assign req.ready      = stg_ready[0];

    for (genvar i = 0; i < NUM_ROUNDS; i++)
    begin : g_round
        des_round u_round (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (stg_valid[i]),
            .up_ready (stg_ready[i]),
            .up_blk   (stg_blk[i]),
            .enc_key  (subkey[i]),
            .dec_key  (subkey[NUM_ROUNDS-1-i]),
            .dn_valid (stg_valid[i+1]),
            .dn_ready (stg_ready[i+1]),
            .dn_blk   (stg_blk[i+1])
        );
    end

    assign stg_ready[NUM_ROUNDS] = rsp.ready;
    assign rsp.valid             = stg_valid[NUM_ROUNDS];
    // halves swap back before the final permutation
    assign rsp.data_out = perm_fp({stg_blk[NUM_ROUNDS].r, stg_blk[NUM_ROUNDS].l});

endmodule

`default_nettype wire
